@@ hdl/fsd_pkg.sv @@
package fsd_pkg;

	localparam int PIX_W      = 8;
	localparam int LWIDTH_W   = 12;
	localparam int LINE_W     = 11;
	localparam int SUM_W      = 29;
	localparam int FN_W       = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [PIX_W-1:0] BLACK_LEVEL = 8'd16;
	localparam logic [PIX_W-1:0] DIFF_OFFSET = 8'd128;

	localparam logic [LWIDTH_W-1:0] LINE_WIDTH_RST = 12'd720;
	localparam logic [LINE_W-1:0]   LINE_COUNT_RST = 11'd576;

	localparam logic [1:0] FO_PROGRESSIVE = 2'd0;
	localparam logic [1:0] FO_TOP_FIRST   = 2'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_WIDTH  = 3'd0,
		CFG_LINE_COUNT  = 3'd1,
		CFG_FIELD_ORDER = 3'd2,
		CFG_OUTPUT_KIND = 3'd3,
		CFG_HOLD_REF    = 3'd4,
		CFG_BLACK_REF   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic frame_end;
		logic odd_line;
	} pos_t;

	typedef struct packed {
		logic [PIX_W-1:0] pd;
		logic [SUM_W-1:0] sum;
		logic [FN_W-1:0]  fn;
		logic             half;
		logic             last;
	} res_t;

	typedef struct packed {
		logic va;
		logic vb;
		res_t a;
		res_t b;
	} push_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage

@@ hdl/fsd_ram.sv @@
module fsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/fsd_addr.sv @@
module fsd_addr #(
	parameter int MAX_WIDTH = 2048,
	parameter int AW        = 21
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [fsd_pkg::LWIDTH_W-1:0]  line_width,
	input  logic [fsd_pkg::LINE_W-1:0]    line_count,
	output logic [AW-1:0]                 addr,
	output fsd_pkg::pos_t                 pos
);

	import fsd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int PW = LINE_W + WW + 1;

	logic [CW-1:0]     col_q;
	logic [LINE_W-1:0] line_q;
	logic [WW-1:0]     width_c;
	logic [LINE_W-1:0] lines_c;
	logic [WW-1:0]     col_inc;
	logic [LINE_W:0]   line_inc;
	logic              col_wrap;
	logic              line_wrap;
	logic [PW-1:0]     prod;

	always_comb begin
		if (line_width == '0) begin
			width_c = WW'(1);
		end else if (32'(line_width) > 32'(MAX_WIDTH)) begin
			width_c = WW'(MAX_WIDTH);
		end else begin
			width_c = WW'(line_width);
		end
		lines_c   = (line_count == '0) ? LINE_W'(1) : line_count;
		col_inc   = {1'b0, col_q} + WW'(1);
		line_inc  = {1'b0, line_q} + (LINE_W + 1)'(1);
		col_wrap  = col_inc >= width_c;
		line_wrap = line_inc >= {1'b0, lines_c};
		prod      = PW'(line_q) * PW'(width_c) + PW'(col_q);
		addr      = AW'(prod);
		pos.frame_end = col_wrap && line_wrap;
		pos.odd_line  = line_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q  <= '0;
				line_q <= line_wrap ? '0 : line_inc[LINE_W-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

endmodule

@@ hdl/fsd_proc.sv @@
module fsd_proc #(
	parameter int AW = 21
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [AW-1:0]              addr,
	input  fsd_pkg::pos_t              pos,
	input  logic [fsd_pkg::PIX_W-1:0]  luma,
	input  logic [fsd_pkg::PIX_W-1:0]  rdata,
	input  logic                       output_kind,
	input  logic [1:0]                 field_order,
	input  logic                       hold_reference,
	input  logic                       black_reference,
	output logic                       ram_we,
	output logic [AW-1:0]              ram_waddr,
	output logic [fsd_pkg::PIX_W-1:0]  ram_wdata,
	output logic                       s1_valid,
	output fsd_pkg::push_t             push
);

	import fsd_pkg::*;

	logic              v_s1;
	logic [PIX_W-1:0]  luma_s1;
	logic [AW-1:0]     addr_s1;
	pos_t              pos_s1;
	logic              fwd_s1;
	logic [PIX_W-1:0]  fwd_data_s1;

	logic              ref_valid_q;
	logic [SUM_W-1:0]  even_q;
	logic [SUM_W-1:0]  odd_q;
	logic [FN_W-1:0]   fc_q;

	logic              cmp;
	logic [PIX_W-1:0]  refv;
	logic [PIX_W-1:0]  ad;
	logic [SUM_W-1:0]  even_nx;
	logic [SUM_W-1:0]  odd_nx;
	logic [FN_W-1:0]   fc_inc;

	assign s1_valid  = v_s1;
	assign ram_we    = v_s1 && (!hold_reference || !ref_valid_q);
	assign ram_waddr = addr_s1;
	assign ram_wdata = luma_s1;

	always_comb begin
		cmp     = black_reference || ref_valid_q;
		refv    = black_reference ? BLACK_LEVEL : (fwd_s1 ? fwd_data_s1 : rdata);
		ad      = (luma_s1 > refv) ? (luma_s1 - refv) : (refv - luma_s1);
		even_nx = pos_s1.odd_line ? even_q : sat_add(even_q, SUM_W'(ad));
		odd_nx  = pos_s1.odd_line ? sat_add(odd_q, SUM_W'(ad)) : odd_q;
		fc_inc  = (fc_q == {FN_W{1'b1}}) ? fc_q : fc_q + FN_W'(1);

		push = '0;
		if (v_s1 && cmp) begin
			if (output_kind) begin
				push.va     = 1'b1;
				push.a.pd   = luma_s1 - refv + DIFF_OFFSET;
				push.a.fn   = fc_inc;
				push.a.last = 1'b1;
			end else if (pos_s1.frame_end) begin
				push.va   = 1'b1;
				push.a.fn = fc_inc;
				push.b.fn = fc_inc;
				case (field_order)
					FO_PROGRESSIVE: begin
						push.a.sum  = sat_add(even_nx, odd_nx);
						push.a.last = 1'b1;
					end
					FO_TOP_FIRST: begin
						push.vb     = 1'b1;
						push.a.sum  = even_nx;
						push.b.sum  = odd_nx;
						push.b.half = 1'b1;
						push.b.last = 1'b1;
					end
					default: begin
						push.vb     = 1'b1;
						push.a.sum  = odd_nx;
						push.b.sum  = even_nx;
						push.b.half = 1'b1;
						push.b.last = 1'b1;
					end
				endcase
			end
		end
	end

	// The word leaving this stage writes the store on the same edge that the
	// next word reads it, so a matching address takes the written pixel instead.
	always_ff @(posedge clk) begin
		luma_s1     <= luma;
		addr_s1     <= addr;
		pos_s1      <= pos;
		fwd_s1      <= ram_we && (addr == addr_s1);
		fwd_data_s1 <= luma_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			ref_valid_q <= 1'b0;
			even_q      <= '0;
			odd_q       <= '0;
			fc_q        <= '0;
		end else begin
			v_s1 <= accept;
			if (v_s1) begin
				if (cmp) begin
					even_q <= even_nx;
					odd_q  <= odd_nx;
				end
				if (pos_s1.frame_end) begin
					if (cmp) begin
						fc_q <= fc_inc;
					end
					even_q      <= '0;
					odd_q       <= '0;
					ref_valid_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ hdl/fsd_oq.sv @@
module fsd_oq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s1_valid,
	input  fsd_pkg::push_t push,
	input  logic           pop,
	output logic           valid,
	output fsd_pkg::res_t  head,
	output logic           room
);

	import fsd_pkg::*;

	localparam int DEPTH = 8;
	localparam int PTR_W = $clog2(DEPTH);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W:0]   cnt_q;
	logic [PTR_W:0]   n_push;
	logic [PTR_W+1:0] need;

	always_comb begin
		n_push = (PTR_W + 1)'(push.va) + (PTR_W + 1)'(push.vb);
		need   = (PTR_W + 2)'(cnt_q) + (s1_valid ? (PTR_W + 2)'(4) : (PTR_W + 2)'(2));
		room   = need <= (PTR_W + 2)'(DEPTH);
		valid  = cnt_q != '0;
		head   = mem_q[rp_q];
	end

	always_ff @(posedge clk) begin
		if (push.va) begin
			mem_q[wp_q] <= push.a;
		end
		if (push.vb) begin
			mem_q[wp_q + PTR_W'(1)] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PTR_W'(n_push);
			rp_q  <= rp_q + PTR_W'(pop && valid);
			cnt_q <= cnt_q + n_push - (PTR_W + 1)'(pop && valid);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PTR_W + 1)'(DEPTH))
		else $error("output queue overflow");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.vb |-> push.va && !push.a.last && !push.a.half && push.b.last && push.b.half)
		else $error("field pair pushed with wrong marks");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.va && !push.vb) |-> push.a.last && !push.a.half)
		else $error("single result not marked last");

	a_push_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		push.va |-> s1_valid)
		else $error("result pushed with no word in flight");

endmodule

@@ hdl/field_sad_frame_difference_core.sv @@
// Luma frame difference core. Pixels enter in raster order at up to one word per clock,
// with no gaps needed between lines or frames. The reference frame lives in one
// synchronous RAM of FRAME_PIXELS bytes that is read on the cycle a pixel is taken and,
// unless the reference is held, written back the following cycle, which is what sets
// the one-pixel-per-clock rate; a read that hits the entry being written takes the new
// pixel directly. Results pass through an eight-entry queue, so in sum mode the two
// field sums of an interlaced frame cost no input cycles while the output side keeps
// up, and in_stall rises only when fewer entries are free than the words in flight
// could need. The store needs no clearing after reset: the first frame only loads it.
// Configuration may be written only while no pixel is in flight.
module field_sad_frame_difference_core #(
	parameter int MAX_WIDTH    = 2048,
	parameter int FRAME_PIXELS = 2097152
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fsd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [fsd_pkg::PIX_W-1:0]        luma,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [fsd_pkg::PIX_W-1:0]        pixel_difference,
	output logic [fsd_pkg::SUM_W-1:0]        field_sum,
	output logic [fsd_pkg::FN_W-1:0]         frame_number,
	output logic                             second_half,
	output logic                             last
);

	import fsd_pkg::*;

	localparam int AW = $clog2(FRAME_PIXELS);

	logic [LWIDTH_W-1:0] line_width_q;
	logic [LINE_W-1:0]   line_count_q;
	logic [1:0]          field_order_q;
	logic                output_kind_q;
	logic                hold_ref_q;
	logic                black_ref_q;

	logic             accept;
	logic             room;
	logic [AW-1:0]    raddr;
	pos_t             pos;
	logic [PIX_W-1:0] rdata;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [PIX_W-1:0] ram_wdata;
	logic             s1_valid;
	push_t            push;
	res_t             head;

	assign in_stall = !room;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q  <= LINE_WIDTH_RST;
			line_count_q  <= LINE_COUNT_RST;
			field_order_q <= FO_PROGRESSIVE;
			output_kind_q <= 1'b0;
			hold_ref_q    <= 1'b0;
			black_ref_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LINE_WIDTH:  line_width_q  <= cfg_data;
				CFG_LINE_COUNT:  line_count_q  <= cfg_data[LINE_W-1:0];
				CFG_FIELD_ORDER: field_order_q <= cfg_data[1:0];
				CFG_OUTPUT_KIND: output_kind_q <= cfg_data[0];
				CFG_HOLD_REF:    hold_ref_q    <= cfg_data[0];
				CFG_BLACK_REF:   black_ref_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	fsd_addr #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_addr (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.line_width (line_width_q),
		.line_count (line_count_q),
		.addr       (raddr),
		.pos        (pos)
	);

	fsd_ram #(
		.WIDTH (PIX_W),
		.DEPTH (FRAME_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	fsd_proc #(
		.AW (AW)
	) u_proc (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.addr            (raddr),
		.pos             (pos),
		.luma            (luma),
		.rdata           (rdata),
		.output_kind     (output_kind_q),
		.field_order     (field_order_q),
		.hold_reference  (hold_ref_q),
		.black_reference (black_ref_q),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.s1_valid        (s1_valid),
		.push            (push)
	);

	fsd_oq u_oq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.push     (push),
		.pop      (!out_stall),
		.valid    (out_valid),
		.head     (head),
		.room     (room)
	);

	assign pixel_difference = head.pd;
	assign field_sum        = head.sum;
	assign frame_number     = head.fn;
	assign second_half      = head.half;
	assign last             = head.last;

endmodule
